@@ hw/rtl/swq_pkg.sv @@
package swq_pkg;

  localparam int unsigned CmdWidth    = 2;
  localparam int unsigned FieldWidth  = 16;
  localparam int unsigned CountWidth  = 7;
  localparam int unsigned StatusWidth = 2;

  localparam logic [CmdWidth-1:0] CMD_PUSH    = 2'd0;
  localparam logic [CmdWidth-1:0] CMD_POP     = 2'd1;
  localparam logic [CmdWidth-1:0] CMD_ENQUEUE = 2'd2;
  localparam logic [CmdWidth-1:0] CMD_DEQUEUE = 2'd3;

  localparam logic [StatusWidth-1:0] STATUS_OK    = 2'd0;
  localparam logic [StatusWidth-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [StatusWidth-1:0] STATUS_FULL  = 2'd2;

  localparam logic QUEUE_A = 1'b0;
  localparam logic QUEUE_B = 1'b1;

  typedef struct packed {
    logic [CmdWidth-1:0]          cmd;
    logic signed [FieldWidth-1:0] value;
    logic                         queue_sel;
  } in_t;

  typedef struct packed {
    logic signed [FieldWidth-1:0] moved_value;
    logic [CountWidth-1:0]        stack_count;
    logic [StatusWidth-1:0]       status;
  } out_t;

endpackage

@@ hw/rtl/swq_ram.sv @@
module swq_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 16,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/stack_with_two_queues.sv @@
// Stack plus two FIFO queues (A, B) and a held-value register.
// Input channel in_valid_i/in_stall_o carries one command beat (push, pop,
// enqueue held value, dequeue to stack); output channel out_valid_o/out_stall_i
// carries exactly one result beat per command: the moved value, the stack
// depth after the command and a status (ok, source empty, destination full).
// A failing command changes no state and reports a zero value.
// A command is accepted in the idle state, which issues the memory reads;
// its result is registered in the execute state once the output register is free.
// The stack and both queues live in memories with a registered read; the
// execute state modifies and writes back. Input stays stalled in the execute
// state, so a new command is not taken before the last one has written back.
// A new command is taken while a finished result still waits in the output
// register; if the receiver stalls, the command in progress waits in the
// execute state and input stays stalled until the result moves.
// Reset clears the stack level, queue heads and fills, the held value and
// the output valid flag. Memory contents are not cleared; read data of an
// entry that was never written is not used.
module stack_with_two_queues #(
  parameter int unsigned STACK_DEPTH = 64,
  parameter int unsigned QUEUE_DEPTH = 64,
  parameter int unsigned VALUE_WIDTH = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  swq_pkg::in_t  in_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output swq_pkg::out_t out_o
);

  localparam int unsigned SAW = $clog2(STACK_DEPTH);
  localparam int unsigned SLW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned QAW = $clog2(QUEUE_DEPTH);
  localparam int unsigned QFW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned TW  = QFW + 1;
  localparam int unsigned VW  = VALUE_WIDTH;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_q, state_d;

  logic [SLW-1:0] level_q, level_d;
  logic [QAW-1:0] head_q [2];
  logic [QAW-1:0] head_d [2];
  logic [QFW-1:0] fill_q [2];
  logic [QFW-1:0] fill_d [2];
  logic [VW-1:0]  held_q, held_d;

  logic [swq_pkg::CmdWidth-1:0] cmd_q;
  logic [VW-1:0]                val_q;
  logic                         sel_q;

  logic          out_valid_q;
  swq_pkg::out_t out_q, out_d;

  logic in_fire, out_fire, out_free, exec_fire;

  logic           stk_we;
  logic [SAW-1:0] stk_waddr;
  logic [VW-1:0]  stk_wdata;
  logic [VW-1:0]  stk_rdata;

  logic           q_we    [2];
  logic [QAW-1:0] q_waddr;
  logic [VW-1:0]  q_rdata [2];
  logic [VW-1:0]  q_front;

  logic [QAW-1:0] cur_head;
  logic [QFW-1:0] cur_fill;
  logic [TW-1:0]  tail_sum;
  logic [QAW-1:0] tail;
  logic [QAW-1:0] head_next;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign out_fire   = out_valid_q && !out_stall_i;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign exec_fire  = (state_q == S_EXEC) && out_free;

  // ---------------------------------------------------------------- memories
  swq_ram #(
    .DEPTH (STACK_DEPTH),
    .WIDTH (VW)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .re_i    (in_fire),
    .raddr_i (SAW'(level_q - SLW'(1))),
    .rdata_o (stk_rdata)
  );

  for (genvar g = 0; g < 2; g++) begin : g_queue
    swq_ram #(
      .DEPTH (QUEUE_DEPTH),
      .WIDTH (VW)
    ) u_queue_ram (
      .clk_i   (clk_i),
      .we_i    (q_we[g]),
      .waddr_i (q_waddr),
      .wdata_i (held_q),
      .re_i    (in_fire),
      .raddr_i (head_q[g]),
      .rdata_o (q_rdata[g])
    );
  end

  // ------------------------------------------------------ read-modify-write
  assign cur_head = head_q[sel_q];
  assign cur_fill = fill_q[sel_q];
  assign q_front  = q_rdata[sel_q];

  always_comb begin
    tail_sum = TW'(cur_head) + TW'(cur_fill);
    if (tail_sum >= TW'(QUEUE_DEPTH)) begin
      tail_sum = tail_sum - TW'(QUEUE_DEPTH);
    end
    tail = tail_sum[QAW-1:0];
    if (cur_head == QAW'(QUEUE_DEPTH - 1)) begin
      head_next = '0;
    end else begin
      head_next = cur_head + QAW'(1);
    end
  end

  assign q_waddr = tail;

  always_comb begin
    level_d   = level_q;
    head_d    = head_q;
    fill_d    = fill_q;
    held_d    = held_q;
    stk_we    = 1'b0;
    stk_waddr = level_q[SAW-1:0];
    stk_wdata = val_q;
    q_we[0]   = 1'b0;
    q_we[1]   = 1'b0;
    out_d.moved_value = '0;
    out_d.status      = swq_pkg::STATUS_OK;

    unique case (cmd_q)
      swq_pkg::CMD_PUSH: begin
        if (level_q == SLW'(STACK_DEPTH)) begin
          out_d.status = swq_pkg::STATUS_FULL;
        end else begin
          stk_we  = exec_fire;
          level_d = level_q + SLW'(1);
          out_d.moved_value = swq_pkg::FieldWidth'(val_q);
        end
      end
      swq_pkg::CMD_POP: begin
        if (level_q == '0) begin
          out_d.status = swq_pkg::STATUS_EMPTY;
        end else begin
          level_d = level_q - SLW'(1);
          held_d  = stk_rdata;
          out_d.moved_value = swq_pkg::FieldWidth'(stk_rdata);
        end
      end
      swq_pkg::CMD_ENQUEUE: begin
        if (cur_fill == QFW'(QUEUE_DEPTH)) begin
          out_d.status = swq_pkg::STATUS_FULL;
        end else begin
          q_we[sel_q]   = exec_fire;
          fill_d[sel_q] = cur_fill + QFW'(1);
          out_d.moved_value = swq_pkg::FieldWidth'(held_q);
        end
      end
      swq_pkg::CMD_DEQUEUE: begin
        if (cur_fill == '0) begin
          out_d.status = swq_pkg::STATUS_EMPTY;
        end else if (level_q == SLW'(STACK_DEPTH)) begin
          out_d.status = swq_pkg::STATUS_FULL;
        end else begin
          stk_we        = exec_fire;
          stk_wdata     = q_front;
          level_d       = level_q + SLW'(1);
          head_d[sel_q] = head_next;
          fill_d[sel_q] = cur_fill - QFW'(1);
          out_d.moved_value = swq_pkg::FieldWidth'(q_front);
        end
      end
      default: begin
        out_d.status = swq_pkg::STATUS_OK;
      end
    endcase

    out_d.stack_count = swq_pkg::CountWidth'(level_d);
  end

  // ------------------------------------------------------------ control
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      level_q     <= '0;
      head_q[0]   <= '0;
      head_q[1]   <= '0;
      fill_q[0]   <= '0;
      fill_q[1]   <= '0;
      held_q      <= '0;
    end else begin
      state_q <= state_d;
      if (exec_fire) begin
        out_valid_q <= 1'b1;
        level_q     <= level_d;
        head_q      <= head_d;
        fill_q      <= fill_d;
        held_q      <= held_d;
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q <= in_i.cmd;
      val_q <= VW'(in_i.value);
      sel_q <= in_i.queue_sel;
    end
    if (exec_fire) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

`ifndef SYNTHESIS
  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level_q <= SLW'(STACK_DEPTH))
    else $error("stack level beyond depth");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q[0] <= QFW'(QUEUE_DEPTH) && fill_q[1] <= QFW'(QUEUE_DEPTH))
    else $error("queue fill beyond depth");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> in_stall_o)
    else $error("command accepted while previous one in progress");

  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.status != swq_pkg::STATUS_OK |-> out_o.moved_value == '0)
    else $error("failed command reports nonzero value");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_o.status == swq_pkg::STATUS_OK ||
      out_o.status == swq_pkg::STATUS_EMPTY || out_o.status == swq_pkg::STATUS_FULL)
    else $error("undefined status code");
`endif

endmodule
